// ===== hw/rtl/fpvd_pkg.sv =====
// Package: shared types and constants for the fixed-point vector distance block.
package fpvd_pkg;

  localparam int unsigned FracBitsDef = 8;
  localparam int unsigned MaxLenDef   = 256;

  localparam int unsigned SadW  = 24;
  localparam int unsigned SatW  = 25;
  localparam int unsigned SsqW  = 40;
  localparam int unsigned MaxW  = 16;
  localparam int unsigned DistW = 40;

  localparam logic [2:0] MetricManhattan = 3'd0;
  localparam logic [2:0] MetricChebyshev = 3'd1;
  localparam logic [2:0] MetricSqEuclid  = 3'd2;
  localparam logic [2:0] MetricEuclid    = 3'd3;
  localparam logic [2:0] MetricBray      = 3'd4;

  localparam logic [15:0] OutSat = 16'd32767;

  // Finished accumulator set handed from front to back
  typedef struct packed {
    logic [2:0]      metric;
    logic [SadW-1:0] sad;
    logic [SatW-1:0] sat;
    logic [SsqW-1:0] ssq;
    logic [MaxW-1:0] mad;
  } acc_t;

endpackage

// ===== hw/rtl/fixed_point_vector_distance.sv =====
// Top level: fixed-point vector distance, front accumulator and back metric unit.
//   channel | dir | signals
//   in      | in  | in_valid_i/in_ready_o, x_value_i, y_value_i, last_i
//   cfg     | in  | cfg_valid_i/cfg_ready_o, cfg_data_i (metric)
//   out     | out | out_valid_o/out_ready_i, distance_o
// Elements are taken one per cycle while the hand-off slot is free or draining;
// a finished vector waits in a one-entry queue. Direct metrics are registered;
// euclidean yields one root bit a cycle, bray-curtis one quotient bit a cycle.
// Reset clears accumulators, metric and all valid flags; no clearing pass.
module fixed_point_vector_distance #(
  parameter int unsigned FracBits = fpvd_pkg::FracBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [15:0]         x_value_i,
  input  logic signed [15:0]         y_value_i,
  input  logic                       last_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [2:0]                 cfg_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [fpvd_pkg::DistW-1:0] distance_o
);

  logic [2:0] metric_q;
  logic acc_valid, acc_ready;
  fpvd_pkg::acc_t acc;

  // Metric register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= fpvd_pkg::MetricManhattan;
    end else if (cfg_valid_i) begin
      metric_q <= cfg_data_i;
    end
  end

  fpvd_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .x_value_i, .y_value_i, .last_i,
    .metric_i(metric_q), .acc_valid_o(acc_valid), .acc_ready_i(acc_ready), .acc_o(acc)
  );

  fpvd_back #(.FracBits(FracBits)) u_back (
    .clk_i, .rst_ni, .acc_valid_i(acc_valid), .acc_ready_o(acc_ready), .acc_i(acc),
    .out_valid_o, .out_ready_i, .distance_o
  );

endmodule

// ===== hw/rtl/fpvd_front.sv =====
// Front: accepts element pairs, accumulates, emits a finished set on last.
module fpvd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [15:0]    x_value_i,
  input  logic signed [15:0]    y_value_i,
  input  logic                  last_i,
  input  logic [2:0]            metric_i,
  output logic                  acc_valid_o,
  input  logic                  acc_ready_i,
  output fpvd_pkg::acc_t        acc_o
);

  logic [fpvd_pkg::SadW-1:0] sad_q, sad_d;
  logic [fpvd_pkg::SatW-1:0] sat_q, sat_d;
  logic [fpvd_pkg::SsqW-1:0] ssq_q, ssq_d;
  logic [fpvd_pkg::MaxW-1:0] mad_q, mad_d;
  logic [16:0] diff, tot;
  logic [16:0] ad, at;
  logic [33:0] sq;
  logic [fpvd_pkg::SadW:0] sad_sum;
  logic [fpvd_pkg::SatW:0] sat_sum;
  logic [fpvd_pkg::SsqW:0] ssq_sum;
  logic acc_valid_q;
  fpvd_pkg::acc_t acc_q;
  logic fire;

  // Front stalls only when the hand-off slot is full and not draining
  assign in_ready_o = !acc_valid_q || acc_ready_i;
  assign fire = in_valid_i && in_ready_o;

  // Element arithmetic
  always_comb begin
    diff = 17'({y_value_i[15], y_value_i}) - 17'({x_value_i[15], x_value_i});
    tot  = 17'({y_value_i[15], y_value_i}) + 17'({x_value_i[15], x_value_i});
    ad   = diff[16] ? 17'(-diff) : diff;
    at   = tot[16] ? 17'(-tot) : tot;
    sq   = 34'(ad) * 34'(ad);
    sad_sum = (fpvd_pkg::SadW+1)'(sad_q) + (fpvd_pkg::SadW+1)'(ad);
    sat_sum = (fpvd_pkg::SatW+1)'(sat_q) + (fpvd_pkg::SatW+1)'(at);
    ssq_sum = (fpvd_pkg::SsqW+1)'(ssq_q) + (fpvd_pkg::SsqW+1)'(sq);
    sad_d = sad_sum[fpvd_pkg::SadW] ? '1 : sad_sum[fpvd_pkg::SadW-1:0];
    sat_d = sat_sum[fpvd_pkg::SatW] ? '1 : sat_sum[fpvd_pkg::SatW-1:0];
    ssq_d = ssq_sum[fpvd_pkg::SsqW] ? '1 : ssq_sum[fpvd_pkg::SsqW-1:0];
    mad_d = (ad > 17'(mad_q)) ? ad[15:0] : mad_q;
  end

  // Accumulators; clear after the last item of a vector
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sad_q <= '0;
      sat_q <= '0;
      ssq_q <= '0;
      mad_q <= '0;
    end else if (fire) begin
      if (last_i) begin
        sad_q <= '0;
        sat_q <= '0;
        ssq_q <= '0;
        mad_q <= '0;
      end else begin
        sad_q <= sad_d;
        sat_q <= sat_d;
        ssq_q <= ssq_d;
        mad_q <= mad_d;
      end
    end
  end

  // One-entry hand-off queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_valid_q <= 1'b0;
    end else if (fire && last_i) begin
      acc_valid_q <= 1'b1;
    end else if (acc_ready_i) begin
      acc_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && last_i) begin
      acc_q.metric <= metric_i;
      acc_q.sad    <= sad_d;
      acc_q.sat    <= sat_d;
      acc_q.ssq    <= ssq_d;
      acc_q.mad    <= mad_d;
    end
  end

  assign acc_valid_o = acc_valid_q;
  assign acc_o       = acc_q;

`ifndef NO_ASSERTIONS
  // Maximum never exceeds the absolute-difference sum while accumulating
  a_max_le_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    24'(mad_q) <= sad_q || sad_q == '1)
    else $error("max above sum");
  // Last item always fills the hand-off slot
  a_last_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && last_i |=> acc_valid_q)
    else $error("last lost");
  // Absolute-difference and squared sums are clear after a last item
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && last_i |=> sad_q == '0 && ssq_q == '0)
    else $error("no clear");
`endif

endmodule

// ===== hw/rtl/fpvd_back.sv =====
// Back: picks the metric, runs square root or division bit by bit, holds the result.
module fpvd_back #(
  parameter int unsigned FracBits = fpvd_pkg::FracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        acc_valid_i,
  output logic                        acc_ready_o,
  input  fpvd_pkg::acc_t              acc_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [fpvd_pkg::DistW-1:0]  distance_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSqrt = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;
  localparam int unsigned NumW  = fpvd_pkg::SadW + FracBits;
  localparam int unsigned CntW  = $clog2(NumW + 1);

  logic [1:0] st_q, st_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  // Square root working registers
  logic [41:0] rem_q, rem_d, res_q, res_d, bit_q, bit_d;
  // Divider working registers
  logic [NumW-1:0] num_q, num_d, quo_q, quo_d;
  logic [fpvd_pkg::SatW:0] part_q, part_d;
  logic [fpvd_pkg::SatW-1:0] den_q, den_d;
  logic [fpvd_pkg::DistW-1:0] dist_q, dist_d;
  logic [41:0] trial;
  logic [fpvd_pkg::SatW:0] shifted;
  fpvd_pkg::acc_t a;

  assign a = acc_i;
  assign acc_ready_o = (st_q == StIdle);
  assign out_valid_o = (st_q == StOut);
  assign distance_o  = dist_q;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q;
    rem_d = rem_q; res_d = res_q; bit_d = bit_q;
    num_d = num_q; quo_d = quo_q; part_d = part_q; den_d = den_q;
    dist_d = dist_q;
    trial = res_q + bit_q;
    shifted = {part_q[fpvd_pkg::SatW-1:0], num_q[NumW-1]};
    unique case (st_q)
      StIdle: begin
        if (acc_valid_i) begin
          st_d = StOut;
          unique case (a.metric)
            fpvd_pkg::MetricManhattan: dist_d = 40'(a.sad);
            fpvd_pkg::MetricChebyshev:
              dist_d = (a.mad > fpvd_pkg::OutSat) ? 40'(fpvd_pkg::OutSat) : 40'(a.mad);
            fpvd_pkg::MetricSqEuclid: dist_d = a.ssq;
            fpvd_pkg::MetricEuclid: begin
              if (a.ssq > 40'(32'd1073676289)) begin
                dist_d = 40'(fpvd_pkg::OutSat);
              end else begin
                rem_d = 42'(a.ssq); res_d = '0; bit_d = 42'(1) << 30;
                st_d = StSqrt;
              end
            end
            fpvd_pkg::MetricBray: begin
              if (a.sat == '0) begin
                dist_d = '0;
              end else begin
                num_d = NumW'(a.sad) << FracBits;
                quo_d = '0; part_d = '0; den_d = a.sat;
                cnt_d = CntW'(NumW);
                st_d = StDiv;
              end
            end
            default: dist_d = '0;
          endcase
        end
      end
      // One result bit per cycle
      StSqrt: begin
        if (rem_q >= trial) begin
          rem_d = rem_q - trial;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q == 42'd1) begin
          dist_d = 40'(res_d);
          st_d = StOut;
        end
      end
      // Restoring division, one quotient bit per cycle
      StDiv: begin
        num_d = num_q << 1;
        if (shifted >= (fpvd_pkg::SatW+1)'(den_q)) begin
          part_d = shifted - (fpvd_pkg::SatW+1)'(den_q);
          quo_d = {quo_q[NumW-2:0], 1'b1};
        end else begin
          part_d = shifted;
          quo_d = {quo_q[NumW-2:0], 1'b0};
        end
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          dist_d = (quo_d > NumW'(fpvd_pkg::OutSat)) ? 40'(fpvd_pkg::OutSat)
                                                  : 40'(quo_d);
          st_d = StOut;
        end
      end
      StOut: begin
        if (out_ready_i) st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StIdle;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; res_q <= res_d; bit_q <= bit_d;
    num_q <= num_d; quo_q <= quo_d; part_q <= part_d; den_q <= den_d;
    dist_q <= dist_d;
  end

`ifndef NO_ASSERTIONS
  // Result held until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_o))
    else $error("result dropped");
  // Divider count stays within range
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StDiv |-> cnt_q != '0)
    else $error("bad count");
  // Takes a set only when idle
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_ready_o |-> !out_valid_o)
    else $error("overlap");
`endif

endmodule

// ===== tb/tb_fixed_point_vector_distance.sv =====
// Testbench for the fixed-point vector distance block: directed table, saturation, random.
module tb_fixed_point_vector_distance;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FracBits = fpvd_pkg::FracBitsDef;
  localparam int unsigned DistW = fpvd_pkg::DistW;
  localparam logic [2:0] MetricUnused = 3'd7;
  localparam int         BackLatency = 40;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic signed [15:0]   x_value_i = '0;
  logic signed [15:0]   y_value_i = '0;
  logic                 last_i = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [2:0]           cfg_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [DistW-1:0]     distance_o;

  fixed_point_vector_distance DUT (.*);

  always #1 clk_i = ~clk_i;

  // Predictor state
  logic [2:0]                metric_q;
  logic [fpvd_pkg::SadW-1:0] sad_q;
  logic [fpvd_pkg::SatW-1:0] sat_q;
  logic [fpvd_pkg::SsqW-1:0] ssq_q;
  logic [fpvd_pkg::MaxW-1:0] mad_q;

  logic [DistW-1:0] dist_queue[$];
  int  errors = 0;
  int  n_items = 0;
  int  n_results = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  metric_hits[8];

  // Directed rows: known distance where read off at a glance, else -1 for predictor
  typedef struct {
    logic [2:0]  metric;
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
    longint      known;
  } row_t;

  function automatic logic [DistW-1:0] isqrt(logic [fpvd_pkg::SsqW-1:0] v);
    logic [fpvd_pkg::SsqW:0] rem;
    logic [fpvd_pkg::SsqW:0] res;
    logic [fpvd_pkg::SsqW:0] bitv;
    rem = (fpvd_pkg::SsqW+1)'(v);
    res = '0;
    bitv = 41'd1 << 40;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res[DistW-1:0];
  endfunction

  // Accumulate one pair, return 1 with the distance on the last pair
  function automatic bit accumulate_pair(logic [15:0] xr, logic [15:0] yr, logic lst,
                                         output logic [DistW-1:0] dist_v);
    int     xs;
    int     ys;
    longint ad;
    longint at;
    longint s;
    xs = $signed(xr);
    ys = $signed(yr);
    ad = (ys - xs < 0) ? xs - ys : ys - xs;
    at = (xs + ys < 0) ? -(xs + ys) : xs + ys;
    s = longint'(sad_q) + ad;
    sad_q = (s > 64'hFFFFFF) ? '1 : s[fpvd_pkg::SadW-1:0];
    s = longint'(sat_q) + at;
    sat_q = (s > 64'h1FFFFFF) ? '1 : s[fpvd_pkg::SatW-1:0];
    s = longint'(ssq_q) + ad * ad;
    ssq_q = (s > 64'hFFFFFFFFFF) ? '1 : s[fpvd_pkg::SsqW-1:0];
    if (ad > mad_q) mad_q = ad[fpvd_pkg::MaxW-1:0];
    dist_v = '0;
    if (!lst) return 1'b0;
    case (metric_q)
      fpvd_pkg::MetricManhattan: dist_v = DistW'(sad_q);
      fpvd_pkg::MetricChebyshev:
        dist_v = (mad_q > fpvd_pkg::OutSat) ? DistW'(fpvd_pkg::OutSat) : DistW'(mad_q);
      fpvd_pkg::MetricSqEuclid:  dist_v = ssq_q;
      fpvd_pkg::MetricEuclid:
        dist_v = (ssq_q > 40'd32767 * 40'd32767) ? DistW'(fpvd_pkg::OutSat) : isqrt(ssq_q);
      fpvd_pkg::MetricBray: begin
        if (sat_q == 0) begin
          dist_v = '0;
        end else begin
          s = (longint'(sad_q) << FracBits) / longint'(sat_q);
          dist_v = (s > fpvd_pkg::OutSat) ? DistW'(fpvd_pkg::OutSat) : s[DistW-1:0];
        end
      end
      default: dist_v = '0;
    endcase
    sad_q = '0;
    sat_q = '0;
    ssq_q = '0;
    mad_q = '0;
    return 1'b1;
  endfunction

  // Send one item, hold valid until accepted; valid drops only when idling or draining
  task automatic send_pair(logic [15:0] xr, logic [15:0] yr, logic lst, longint known);
    logic [DistW-1:0] d;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_value_i  <= xr;
    y_value_i  <= yr;
    last_i     <= lst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (accumulate_pair(xr, yr, lst, d)) begin
      if (known >= 0 && d != DistW'(known)) begin
        $error("distance (table row): expected %0d, predicted %0d", known, d);
        errors++;
      end
      dist_queue.push_back(d);
      metric_hits[metric_q]++;
    end
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (dist_queue.size() != 0 && guard < 100000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (BackLatency) @(negedge clk_i);
  endtask

  // Register write while idle
  task automatic write_metric(logic [2:0] m);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    metric_q = m;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver: stall at random, check against oldest expectation
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (dist_queue.size() == 0) begin
        $error("distance %0d with no item outstanding", distance_o);
        errors++;
      end else begin
        logic [DistW-1:0] exp_d;
        exp_d = dist_queue.pop_front();
        if (distance_o !== exp_d) begin
          $error("distance: expected %0d, actual %0d", exp_d, distance_o);
          errors++;
        end
      end
      n_results++;
    end
  end

  // Random, extreme, small or negated pairs; mostly short, a few long enough to saturate
  task automatic random_vector(int len, int mode);
    logic [15:0] xr;
    logic [15:0] yr;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: begin xr = 16'($urandom); yr = 16'($urandom); end
        1: begin xr = 16'h8000; yr = 16'h7FFF; end
        2: begin xr = 16'($urandom_range(255)); yr = xr + 16'($urandom_range(3)); end
        4: begin xr = 16'h8000; yr = 16'h8000; end
        default: begin xr = 16'($urandom); yr = -xr; end
      endcase
      send_pair(xr, yr, i == len - 1, -1);
    end
  endtask

  row_t table_rows[$];

  initial begin
    int phase;
    int len;
    for (int i = 0; i < 8; i++) metric_hits[i] = 0;
    metric_q = fpvd_pkg::MetricManhattan;
    sad_q = '0; sat_q = '0; ssq_q = '0; mad_q = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table
    table_rows = '{
      '{fpvd_pkg::MetricManhattan, 16'h0000, 16'h0000, 1'b1, 0},
      '{fpvd_pkg::MetricManhattan, 16'h8000, 16'h7FFF, 1'b1, 65535},
      '{fpvd_pkg::MetricChebyshev, 16'h8000, 16'h7FFF, 1'b1, 32767},
      '{fpvd_pkg::MetricChebyshev, 16'h0000, 16'h0005, 1'b1, 5},
      '{fpvd_pkg::MetricSqEuclid,  16'h8000, 16'h7FFF, 1'b1, 64'd4294836225},
      '{fpvd_pkg::MetricSqEuclid,  16'h0003, 16'h0007, 1'b0, -1},
      '{fpvd_pkg::MetricSqEuclid,  16'hFFFF, 16'h0002, 1'b1, 25},
      '{fpvd_pkg::MetricEuclid,    16'h0000, 16'h0003, 1'b0, -1},
      '{fpvd_pkg::MetricEuclid,    16'h0000, 16'h0004, 1'b1, 5},
      '{fpvd_pkg::MetricEuclid,    16'h8000, 16'h7FFF, 1'b1, 32767},
      '{fpvd_pkg::MetricEuclid,    16'h0000, 16'h7FFF, 1'b1, 32767},
      '{fpvd_pkg::MetricBray,      16'h0000, 16'h0000, 1'b1, 0},
      '{fpvd_pkg::MetricBray,      16'h0005, 16'hFFFB, 1'b1, 0},
      '{fpvd_pkg::MetricBray,      16'h0001, 16'h0003, 1'b1, 128},
      '{fpvd_pkg::MetricBray,      16'h7FFF, 16'h7FFF, 1'b1, 0},
      '{MetricUnused,              16'h1234, 16'h4321, 1'b1, 0},
      '{3'd5,                      16'h8000, 16'h0000, 1'b1, 0},
      '{3'd6,                      16'h0000, 16'h8000, 1'b1, 0},
      '{fpvd_pkg::MetricManhattan, 16'hAAAA, 16'h5555, 1'b0, -1},
      '{fpvd_pkg::MetricManhattan, 16'h5555, 16'hAAAA, 1'b1, -1}
    };
    foreach (table_rows[i]) begin
      if (table_rows[i].metric != metric_q) write_metric(table_rows[i].metric);
      send_pair(table_rows[i].x, table_rows[i].y, table_rows[i].last, table_rows[i].known);
    end

    // Saturation of every sum: long vectors of extreme pairs
    write_metric(fpvd_pkg::MetricManhattan);
    random_vector(300, 1);
    write_metric(fpvd_pkg::MetricSqEuclid);
    random_vector(300, 1);
    write_metric(fpvd_pkg::MetricBray);
    random_vector(520, 4);

    // Random phases, idling patterns rotate, metric changes between phases
    phase = 0;
    while (n_items < 1750) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      write_metric(phase % 5 == 4 && $urandom_range(3) == 0 ? MetricUnused : 3'(phase % 5));
      repeat (12) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
        random_vector(len, ($urandom_range(9) < 7) ? 0 : $urandom_range(3, 2));
      end
      // hold the sender until everything outstanding has arrived
      if (phase == 3) drain();
      phase++;
    end

    drain();
    $display("Covered %0d items, %0d distances; per metric 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             n_items, n_results, metric_hits[0], metric_hits[1], metric_hits[2],
             metric_hits[3], metric_hits[4], metric_hits[5], metric_hits[6], metric_hits[7]);
    $display("Sums driven to saturation, all idling patterns and every metric code written.");
    if (errors == 0 && dist_queue.size() == 0) begin
      $display("fixed_point_vector_distance regression: pass");
    end else begin
      $display("fixed_point_vector_distance regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("fixed_point_vector_distance regression: fail");
    $finish;
  end

endmodule
